### rtl/ps2mpt_pkg.sv
package ps2mpt_pkg;

  localparam int CURSOR_WIDTH_DEF = 12;
  localparam int POS_BITS_DEF     = 12;

  localparam int SET_BITS   = 12;
  localparam int DIM_BITS   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int PKT_LEN    = 3;
  localparam int Q_DEPTH    = 2;

  localparam logic [7:0] BTN_LEFT  = 8'h01;
  localparam logic [7:0] BTN_RIGHT = 8'h02;

  localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = 12'd1024;
  localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = 12'd768;
  localparam logic                WHEEL_MODE_RST    = 1'b0;
  localparam logic                STATUS_LAST_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_WHEEL_MODE    = 2'd2,
    CFG_STATUS_LAST   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_PACKET = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] screen_width;
    logic [DIM_BITS-1:0] screen_height;
    logic                wheel_mode;
    logic                status_last;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SET_BITS-1:0] set_x;
    logic [SET_BITS-1:0] set_y;
    logic [7:0]          status;
    logic [7:0]          dx;
    logic [7:0]          dy;
  } cmd_t;

endpackage

### rtl/ps2mpt_front.sv
module ps2mpt_front import ps2mpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [7:0]          in_rx_byte,
  input  logic [SET_BITS-1:0] in_set_x,
  input  logic [SET_BITS-1:0] in_set_y,
  output logic                push,
  output cmd_t                push_cmd,
  input  logic                q_full
);

  logic [1:0] idx_r, idx_nxt;
  logic [7:0] pkt_r [PKT_LEN];
  logic [2:0] next_cnt;
  logic [2:0] need_cnt;
  logic       complete;
  logic [7:0] b0, b1, b2;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    next_cnt = {1'b0, idx_r} + 3'd1;
    need_cnt = 3'(PKT_LEN) + {2'b00, cfg.wheel_mode};
    complete = (next_cnt >= need_cnt);
    b0 = pkt_r[0];
    b1 = pkt_r[1];
    b2 = (idx_r == 2'd2) ? in_rx_byte : pkt_r[2];

    push_cmd.set_x  = in_set_x;
    push_cmd.set_y  = in_set_y;
    if (cfg.status_last) begin
      push_cmd.dx     = b0;
      push_cmd.dy     = b1;
      push_cmd.status = b2;
    end else begin
      push_cmd.status = b0;
      push_cmd.dx     = b1;
      push_cmd.dy     = b2;
    end

    idx_nxt = idx_r;
    if (in_opcode == OP_SET) begin
      push_cmd.kind = CMD_SET;
    end else if (complete) begin
      push_cmd.kind = CMD_PACKET;
      idx_nxt       = 2'd0;
    end else begin
      push_cmd.kind = CMD_BYTE;
      idx_nxt       = next_cnt[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (push) begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && in_opcode == OP_DATA) begin
      unique case (idx_r)
        2'd0:    pkt_r[0] <= in_rx_byte;
        2'd1:    pkt_r[1] <= in_rx_byte;
        2'd2:    pkt_r[2] <= in_rx_byte;
        default: ;
      endcase
    end
  end

endmodule

### rtl/ps2mpt_queue.sv
module ps2mpt_queue import ps2mpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/ps2mpt_back.sv
module ps2mpt_back import ps2mpt_pkg::*; #(
  parameter int CURSOR_WIDTH = CURSOR_WIDTH_DEF,
  parameter int POS_BITS     = POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                q_valid,
  input  cmd_t                cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [POS_BITS-1:0] out_pos_x,
  output logic [POS_BITS-1:0] out_pos_y,
  output logic                out_left_pressed,
  output logic                out_right_pressed,
  output logic                out_packet_done,
  output logic                out_move_applied
);

  localparam int CMP_W = ((POS_BITS > DIM_BITS) ? POS_BITS : DIM_BITS) + 2;

  logic [POS_BITS-1:0] track_x_r, track_x_nxt;
  logic [POS_BITS-1:0] track_y_r, track_y_nxt;
  logic [POS_BITS-1:0] rep_x_r, rep_x_nxt;
  logic [POS_BITS-1:0] rep_y_r, rep_y_nxt;
  logic                left_r, left_nxt;
  logic                right_r, right_nxt;
  logic                done_nxt, moved_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_BITS-1:0] out_x_r, out_y_r;
  logic                out_left_r, out_right_r, out_done_r, out_moved_r;

  logic signed [CMP_W-1:0] nx, ny, x_lim, y_lim;
  logic                    in_bounds;

  assign pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    nx    = signed'(CMP_W'(track_x_r)) + CMP_W'(signed'(cmd.dx));
    ny    = signed'(CMP_W'(track_y_r)) - CMP_W'(signed'(cmd.dy));
    x_lim = signed'(CMP_W'(cfg.screen_width) - CMP_W'(CURSOR_WIDTH));
    y_lim = signed'(CMP_W'(cfg.screen_height));
    in_bounds = (nx > 0) && (nx < x_lim) && (ny > 0) && (ny < y_lim);

    track_x_nxt = track_x_r;
    track_y_nxt = track_y_r;
    rep_x_nxt   = rep_x_r;
    rep_y_nxt   = rep_y_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    done_nxt    = 1'b0;
    moved_nxt   = 1'b0;

    unique case (cmd.kind)
      CMD_SET: begin
        rep_x_nxt = POS_BITS'(cmd.set_x);
        rep_y_nxt = POS_BITS'(cmd.set_y);
      end
      CMD_PACKET: begin
        done_nxt  = 1'b1;
        left_nxt  = |(cmd.status & BTN_LEFT);
        right_nxt = |(cmd.status & BTN_RIGHT);
        if (in_bounds) begin
          track_x_nxt = nx[POS_BITS-1:0];
          track_y_nxt = ny[POS_BITS-1:0];
          rep_x_nxt   = nx[POS_BITS-1:0];
          rep_y_nxt   = ny[POS_BITS-1:0];
          moved_nxt   = 1'b1;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_x_r   <= '0;
      track_y_r   <= '0;
      rep_x_r     <= '0;
      rep_y_r     <= '0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        track_x_r <= track_x_nxt;
        track_y_r <= track_y_nxt;
        rep_x_r   <= rep_x_nxt;
        rep_y_r   <= rep_y_nxt;
        left_r    <= left_nxt;
        right_r   <= right_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_x_r     <= rep_x_nxt;
      out_y_r     <= rep_y_nxt;
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_done_r  <= done_nxt;
      out_moved_r <= moved_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = out_x_r;
  assign out_pos_y         = out_y_r;
  assign out_left_pressed  = out_left_r;
  assign out_right_pressed = out_right_r;
  assign out_packet_done   = out_done_r;
  assign out_move_applied  = out_moved_r;

endmodule

### rtl/ps2_mouse_packet_tracker_unit.sv
// PS/2 mouse packet tracker. Takes one word per cycle, sustained, and returns one
// result word for every input word, in order. A front stage counts received bytes
// into 3-byte packets (4 in wheel mode, the wheel byte dropped) and tags each word
// as a set command, a plain byte or a completed packet; a 2-entry queue carries the
// tagged word to the back stage, which owns the tracked and reported position and
// does one add and bounds compare per word before the output register. A word
// is registered in the queue and then in the output register; a stalled output
// fills the queue and then drops in_ready. Configuration writes are taken on any
// cycle with cfg_ready tied high and must only be issued while the block is idle.
module ps2_mouse_packet_tracker_unit import ps2mpt_pkg::*; #(
  parameter int CURSOR_WIDTH = CURSOR_WIDTH_DEF,
  parameter int POS_BITS     = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [7:0]            in_rx_byte,
  input  logic [SET_BITS-1:0]   in_set_x,
  input  logic [SET_BITS-1:0]   in_set_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_BITS-1:0]   out_pos_x,
  output logic [POS_BITS-1:0]   out_pos_y,
  output logic                  out_left_pressed,
  output logic                  out_right_pressed,
  output logic                  out_packet_done,
  output logic                  out_move_applied
);

  cfg_t cfg_r, cfg_nxt;
  logic push, q_full, pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_data[DIM_BITS-1:0];
        CFG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_data[DIM_BITS-1:0];
        CFG_WHEEL_MODE:    cfg_nxt.wheel_mode    = cfg_data[0];
        CFG_STATUS_LAST:   cfg_nxt.status_last   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= SCREEN_WIDTH_RST;
      cfg_r.screen_height <= SCREEN_HEIGHT_RST;
      cfg_r.wheel_mode    <= WHEEL_MODE_RST;
      cfg_r.status_last   <= STATUS_LAST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ps2mpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .in_set_x   (in_set_x),
    .in_set_y   (in_set_y),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  ps2mpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  ps2mpt_back #(
    .CURSOR_WIDTH (CURSOR_WIDTH),
    .POS_BITS     (POS_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .cmd               (pop_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_left_pressed  (out_left_pressed),
    .out_right_pressed (out_right_pressed),
    .out_packet_done   (out_packet_done),
    .out_move_applied  (out_move_applied)
  );

endmodule

### rtl/ps2mpt_checker.sv
module ps2mpt_checker #(
  parameter int POS_BITS = 12
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [POS_BITS-1:0] out_pos_x,
  input logic [POS_BITS-1:0] out_pos_y,
  input logic                out_left_pressed,
  input logic                out_right_pressed,
  input logic                out_packet_done,
  input logic                out_move_applied
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y) &&
      $stable(out_left_pressed) && $stable(out_right_pressed) &&
      $stable(out_packet_done) && $stable(out_move_applied))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_move_needs_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_applied |-> out_packet_done)
    else $error("move reported without a completed packet");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker #(
  .POS_BITS (POS_BITS)
) u_ps2mpt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pos_x         (out_pos_x),
  .out_pos_y         (out_pos_y),
  .out_left_pressed  (out_left_pressed),
  .out_right_pressed (out_right_pressed),
  .out_packet_done   (out_packet_done),
  .out_move_applied  (out_move_applied)
);

### tb/ps2_mouse_packet_tracker_unit_tb.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_unit_tb import ps2mpt_pkg::*;;

  localparam int CURSOR_W      = CURSOR_WIDTH_DEF;
  localparam int PW            = POS_BITS_DEF;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 90;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [PW-1:0] pos_x;
    logic [PW-1:0] pos_y;
    logic          left_btn;
    logic          right_btn;
    logic          done;
    logic          moved;
  } mouse_report_t;

  class cursor_tracker_model;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic                wheel;
    logic                stat_last;
    logic [1:0]          byte_cnt;
    logic [7:0]          pkt_buf[3];
    logic [PW-1:0]       trk_x;
    logic [PW-1:0]       trk_y;
    logic [PW-1:0]       rep_x;
    logic [PW-1:0]       rep_y;
    logic                left_st;
    logic                right_st;
    mouse_report_t       due_reports[$];
    int                  errors;
    int                  words;
    int                  results;
    int                  packets;
    int                  moves;

    function new();
      width     = SCREEN_WIDTH_RST;
      height    = SCREEN_HEIGHT_RST;
      wheel     = WHEEL_MODE_RST;
      stat_last = STATUS_LAST_RST;
      byte_cnt  = '0;
      trk_x     = '0;
      trk_y     = '0;
      rep_x     = '0;
      rep_y     = '0;
      left_st   = 1'b0;
      right_st  = 1'b0;
      errors    = 0;
      words     = 0;
      results   = 0;
      packets   = 0;
      moves     = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SCREEN_WIDTH:  width     = d;
        CFG_SCREEN_HEIGHT: height    = d;
        CFG_WHEEL_MODE:    wheel     = d[0];
        CFG_STATUS_LAST:   stat_last = d[0];
        default: ;
      endcase
    endfunction

    function void note_input(opcode_t op, logic [7:0] rx, logic [SET_BITS-1:0] sx,
                             logic [SET_BITS-1:0] sy);
      mouse_report_t r;
      logic [2:0]    nxt;
      logic [7:0]    st;
      logic [7:0]    bx;
      logic [7:0]    by;
      int            nx;
      int            ny;
      r.done  = 1'b0;
      r.moved = 1'b0;
      words++;
      if (op == OP_SET) begin
        rep_x = sx;
        rep_y = sy;
      end else begin
        nxt = {1'b0, byte_cnt} + 3'd1;
        if (byte_cnt < 2'd3) pkt_buf[byte_cnt] = rx;
        if (int'(nxt) >= PKT_LEN + int'(wheel)) begin
          byte_cnt = '0;
          r.done   = 1'b1;
          packets++;
          if (stat_last) {bx, by, st} = {pkt_buf[0], pkt_buf[1], pkt_buf[2]};
          else {st, bx, by} = {pkt_buf[0], pkt_buf[1], pkt_buf[2]};
          left_st  = (st & BTN_LEFT) != 8'h00;
          right_st = (st & BTN_RIGHT) != 8'h00;
          nx = int'(trk_x) + int'($signed(bx));
          ny = int'(trk_y) - int'($signed(by));
          if (nx < int'(width) - CURSOR_W && nx > 0 && ny < int'(height) && ny > 0) begin
            trk_x   = nx[PW-1:0];
            trk_y   = ny[PW-1:0];
            rep_x   = trk_x;
            rep_y   = trk_y;
            r.moved = 1'b1;
            moves++;
          end
        end else begin
          byte_cnt = nxt[1:0];
        end
      end
      r.pos_x     = rep_x;
      r.pos_y     = rep_y;
      r.left_btn  = left_st;
      r.right_btn = right_st;
      due_reports.push_back(r);
    endfunction

    task note_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_result(mouse_report_t got);
      mouse_report_t want;
      results++;
      if (due_reports.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results));
        return;
      end
      want = due_reports.pop_front();
      if (got.pos_x !== want.pos_x)
        note_mismatch($sformatf("result %0d pos_x got %0d want %0d", results,
                                got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        note_mismatch($sformatf("result %0d pos_y got %0d want %0d", results,
                                got.pos_y, want.pos_y));
      if (got.left_btn !== want.left_btn)
        note_mismatch($sformatf("result %0d left_pressed got %b want %b", results,
                                got.left_btn, want.left_btn));
      if (got.right_btn !== want.right_btn)
        note_mismatch($sformatf("result %0d right_pressed got %b want %b", results,
                                got.right_btn, want.right_btn));
      if (got.done !== want.done)
        note_mismatch($sformatf("result %0d packet_done got %b want %b", results,
                                got.done, want.done));
      if (got.moved !== want.moved)
        note_mismatch($sformatf("result %0d move_applied got %b want %b", results,
                                got.moved, want.moved));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_opcode;
  logic [7:0]            in_rx_byte;
  logic [SET_BITS-1:0]   in_set_x;
  logic [SET_BITS-1:0]   in_set_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [PW-1:0]         out_pos_x;
  logic [PW-1:0]         out_pos_y;
  logic                  out_left_pressed;
  logic                  out_right_pressed;
  logic                  out_packet_done;
  logic                  out_move_applied;

  cursor_tracker_model tracker = new();
  mouse_report_t       seen;
  bit                  steady;
  int                  hold_asks;
  int                  hold_served;
  int                  quiet_cycles;
  int                  settings;

  ps2_mouse_packet_tracker_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .in_set_x         (in_set_x),
    .in_set_y         (in_set_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_left_pressed (out_left_pressed),
    .out_right_pressed(out_right_pressed),
    .out_packet_done  (out_packet_done),
    .out_move_applied (out_move_applied)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // steer towards a point inside the bounds, or wander
  function automatic logic [7:0] pick_step(int cur, int lim, bit invert);
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 40 && lim > 1) begin
      d = int'($urandom_range(1, lim - 1)) - cur;
      if (invert) d = -d;
      if (d > 127) d = 127;
      if (d < -128) d = -128;
    end else if (r < 75) begin
      d = int'($urandom_range(0, 30)) - 15;
    end else if (r < 80) begin
      d = 127;
    end else if (r < 85) begin
      d = -128;
    end else begin
      d = $urandom_range(0, 255);
    end
    return d[7:0];
  endfunction

  function automatic logic [SET_BITS-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SET_BITS'($urandom_range(0, 4095));
  endfunction

  task automatic offer(opcode_t op, logic [7:0] b, logic [SET_BITS-1:0] sx,
                       logic [SET_BITS-1:0] sy);
    int g;
    g = idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= b;
    in_set_x   <= sx;
    in_set_y   <= sy;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(op, b, sx, sy);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    offer(OP_DATA, b, SET_BITS'($urandom_range(0, 4095)), SET_BITS'($urandom_range(0, 4095)));
  endtask

  task automatic send_set(logic [SET_BITS-1:0] sx, logic [SET_BITS-1:0] sy);
    offer(OP_SET, 8'($urandom_range(0, 255)), sx, sy);
  endtask

  task automatic send_packet(logic [7:0] st, logic [7:0] dx, logic [7:0] dy);
    if (tracker.stat_last) begin
      send_byte(dx);
      send_byte(dy);
      send_byte(st);
    end else begin
      send_byte(st);
      send_byte(dx);
      send_byte(dy);
    end
    if (tracker.wheel) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h, logic wh,
                              logic sl);
    logic [CFG_DATA_W-2:0] junk;
    junk = 11'($urandom);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_WHEEL_MODE, {junk, wh});
    junk = 11'($urandom);
    write_reg(CFG_STATUS_LAST, {junk, sl});
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic set_wheel(logic wh);
    write_reg(CFG_WHEEL_MODE, {11'($urandom), wh});
    cfg_valid <= 1'b0;
  endtask

  // hold the input low until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_traffic(int n);
    int sent;
    int r;
    int xlim;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_set(pick_coord(), pick_coord());
        sent++;
      end else if (r < 16 || tracker.byte_cnt != 2'd0) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        xlim = int'(tracker.width) - CURSOR_W;
        send_packet(8'($urandom_range(0, 255)),
                    pick_step(int'(tracker.trk_x), xlim, 1'b0),
                    pick_step(int'(tracker.trk_y), int'(tracker.height), 1'b1));
        sent += tracker.wheel ? 4 : 3;
      end
    end
  endtask

  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_asks) begin
        hold_served++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      seen = {out_pos_x, out_pos_y, out_left_pressed, out_right_pressed, out_packet_done,
              out_move_applied};
      tracker.check_result(seen);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, tracker.due_reports.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_opcode    = OP_DATA;
    in_rx_byte   = '0;
    in_set_x     = '0;
    in_set_y     = '0;
    steady       = 1'b0;
    hold_asks    = 0;
    hold_served  = 0;
    quiet_cycles = 0;
    settings     = 1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: x, y, status order, three-byte packets
    send_packet(8'h03, 8'h05, 8'hFB);
    send_packet(8'h01, 8'h7F, 8'h80);
    send_packet(8'hFC, 8'h80, 8'h7F);
    send_packet(8'h02, 8'h80, 8'h00);
    send_set(12'hFFF, 12'h000);
    send_set(12'h000, 12'hFFF);
    // set command in the middle of a packet
    send_byte(8'h10);
    send_set(12'h123, 12'h456);
    send_byte(8'h00);
    send_byte(8'h08);
    send_packet(8'h00, 8'h00, 8'h06);
    settle();

    program_regs(12'd1024, 12'd768, 1'b1, 1'b0);
    send_packet(8'h01, 8'h0A, 8'hF6);
    // wheel mode dropped with three bytes held
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'hFD);
    settle();
    set_wheel(1'b0);
    send_byte(8'hA5);
    // wheel mode raised with two bytes held
    send_byte(8'h01);
    send_byte(8'h04);
    settle();
    set_wheel(1'b1);
    send_byte(8'hFC);
    send_byte(8'h5A);
    settle();

    for (int p = 0; p < 7; p++) begin
      steady = (p % 3 == 1);
      case (p)
        0: program_regs(12'd1024, 12'd768, 1'b0, 1'b1);
        1: program_regs(12'd16, 12'd16, 1'b1, 1'b0);
        2: program_regs(12'd4095, 12'd4095, 1'b0, 1'b0);
        3: program_regs(12'd8, 12'd300, 1'b1, 1'b1);
        default: program_regs(DIM_BITS'($urandom_range(16, 4095)),
                              DIM_BITS'($urandom_range(16, 4095)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      run_traffic(75);
      if (p == 0 || p == 4) hold_asks++;
      if (p == 2) settle();
      run_traffic(75);
      settle();
    end

    $display("Run covered %0d input words and %0d results over %0d register settings",
             tracker.words, tracker.results, settings);
    $display("%0d packets completed, %0d moves applied, %0d mismatches",
             tracker.packets, tracker.moves, tracker.errors);
    if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
